// File: hdl/tcce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and codes of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int KIND_W = 2;
    localparam int CNT_W  = 3;

    // Command codes
    localparam logic CMD_PRINT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NULL  = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    localparam logic [CNT_W-1:0] TAB_SPACES = 3'd4;

    typedef struct packed {
        logic              command;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_column;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [CHAR_W-1:0] char_value;
        logic              last;
    } result_t;

endpackage

// File: hdl/tcce_grid_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_grid_ram
// Character grid store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcce_grid_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [tcce_pkg::CHAR_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [tcce_pkg::CHAR_W-1:0] rd_data
);

    logic [tcce_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [tcce_pkg::CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/tcce_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_seq
// Cursor sequencer: walks one item through grid reads, writes and row clears.
// ----------------------------------------------------------------------------
module tcce_seq #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80,
    parameter int RW      = 5,
    parameter int CW      = 7,
    parameter int AW      = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tcce_pkg::item_t             in_item,
    output logic                        emit_valid,
    input  logic                        emit_ready,
    output tcce_pkg::result_t           emit_res,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [tcce_pkg::CHAR_W-1:0] wr_data,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  logic [tcce_pkg::CHAR_W-1:0] rd_data
);

    localparam int RSW = RW + 1;
    localparam logic [CW-1:0]  LAST_COL   = CW'(COLUMNS - 1);
    localparam logic [RW-1:0]  LAST_ROW   = RW'(ROWS - 1);
    localparam logic [AW-1:0]  COL_STEP   = AW'(COLUMNS);
    localparam logic [AW-1:0]  DEPTH_LAST = AW'(ROWS * COLUMNS - 1);
    localparam logic [RSW-1:0] ROWS_W     = RSW'(ROWS);

    localparam logic [3:0] ST_INIT    = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_RD_ROW  = 4'd2;
    localparam logic [3:0] ST_RD_ADDR = 4'd3;
    localparam logic [3:0] ST_RD_DATA = 4'd4;
    localparam logic [3:0] ST_NEWLINE = 4'd5;
    localparam logic [3:0] ST_SCROLL  = 4'd6;
    localparam logic [3:0] ST_CLEAR   = 4'd7;
    localparam logic [3:0] ST_PUT     = 4'd8;

    logic [3:0]                  state_reg, state_next;
    logic [AW-1:0]               init_addr_reg, init_addr_next;
    logic [RW-1:0]               row_reg, row_next;
    logic [CW-1:0]               col_reg, col_next;
    logic [RW-1:0]               prow_reg, prow_next;
    logic [AW-1:0]               base_reg, base_next;
    logic [RW-1:0]               top_reg, top_next;
    logic [AW-1:0]               top_base_reg, top_base_next;
    logic [tcce_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]               clr_col_reg, clr_col_next;

    logic [tcce_pkg::CHAR_W-1:0] put_char_reg, put_char_next;
    logic [tcce_pkg::ROW_W-1:0]  rd_row_reg, rd_row_next;
    logic [tcce_pkg::COL_W-1:0]  rd_col_reg, rd_col_next;
    logic [RW-1:0]               rd_prow_reg, rd_prow_next;
    logic                        rd_in_range_reg, rd_in_range_next;

    logic [RSW-1:0]              rd_sum;

    assign in_ready = (state_reg == ST_IDLE);
    assign rd_sum   = RSW'(rd_row_reg) + RSW'(top_reg);

    always_comb
    begin
        state_next       = state_reg;
        init_addr_next   = init_addr_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        prow_next        = prow_reg;
        base_next        = base_reg;
        top_next         = top_reg;
        top_base_next    = top_base_reg;
        cnt_next         = cnt_reg;
        clr_col_next     = clr_col_reg;
        put_char_next    = put_char_reg;
        rd_row_next      = rd_row_reg;
        rd_col_next      = rd_col_reg;
        rd_prow_next     = rd_prow_reg;
        rd_in_range_next = rd_in_range_reg;

        emit_valid = 1'b0;
        emit_res   = '0;
        wr_en      = 1'b0;
        wr_addr    = base_reg + AW'(col_reg);
        wr_data    = put_char_reg;
        rd_en      = 1'b0;
        rd_addr    = AW'(rd_prow_reg) * COL_STEP + AW'(rd_col_reg);

        case (state_reg)
            ST_INIT:
            begin
                // sweep the whole grid to zero after reset
                wr_en          = 1'b1;
                wr_addr        = init_addr_reg;
                wr_data        = '0;
                init_addr_next = init_addr_reg + AW'(1);
                if (init_addr_reg == DEPTH_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rd_row_next = in_item.read_row;
                    rd_col_next = in_item.read_column;
                    if (in_item.command == tcce_pkg::CMD_READ)
                    begin
                        state_next = ST_RD_ROW;
                    end
                    else if (in_item.char_code == tcce_pkg::CH_NULL)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (in_item.char_code == tcce_pkg::CH_NL)
                    begin
                        cnt_next   = '0;
                        state_next = ST_NEWLINE;
                    end
                    else if (in_item.char_code == tcce_pkg::CH_CR)
                    begin
                        col_next = '0;
                    end
                    else if (in_item.char_code == tcce_pkg::CH_TAB && col_reg != LAST_COL)
                    begin
                        cnt_next      = tcce_pkg::TAB_SPACES;
                        put_char_next = tcce_pkg::CH_SPACE;
                        state_next    = ST_PUT;
                    end
                    else
                    begin
                        // a tab at the last column is stored raw
                        cnt_next      = tcce_pkg::CNT_W'(1);
                        put_char_next = in_item.char_code;
                        state_next    = ST_PUT;
                    end
                end
            end

            ST_RD_ROW:
            begin
                rd_in_range_next = (32'(rd_row_reg) < ROWS) && (32'(rd_col_reg) < COLUMNS);
                if (rd_sum >= ROWS_W)
                begin
                    rd_prow_next = RW'(rd_sum - ROWS_W);
                end
                else
                begin
                    rd_prow_next = RW'(rd_sum);
                end
                state_next = ST_RD_ADDR;
            end

            ST_RD_ADDR:
            begin
                rd_en      = 1'b1;
                state_next = ST_RD_DATA;
            end

            ST_RD_DATA:
            begin
                emit_valid          = 1'b1;
                emit_res.kind       = tcce_pkg::KIND_READ;
                emit_res.row        = rd_row_reg;
                emit_res.column     = rd_col_reg;
                emit_res.char_value = rd_in_range_reg ? rd_data : '0;
                emit_res.last       = 1'b1;
                if (emit_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_NEWLINE:
            begin
                col_next = '0;
                if (row_reg != LAST_ROW)
                begin
                    row_next = row_reg + RW'(1);
                    if (prow_reg == LAST_ROW)
                    begin
                        prow_next = '0;
                        base_next = '0;
                    end
                    else
                    begin
                        prow_next = prow_reg + RW'(1);
                        base_next = base_reg + COL_STEP;
                    end
                    state_next = (cnt_reg != '0) ? ST_PUT : ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCROLL;
                end
            end

            ST_SCROLL:
            begin
                emit_valid    = 1'b1;
                emit_res.kind = tcce_pkg::KIND_SCROLL;
                emit_res.last = (cnt_reg == '0);
                if (emit_ready)
                begin
                    // the old top row becomes the bottom row
                    prow_next = top_reg;
                    base_next = top_base_reg;
                    if (top_reg == LAST_ROW)
                    begin
                        top_next      = '0;
                        top_base_next = '0;
                    end
                    else
                    begin
                        top_next      = top_reg + RW'(1);
                        top_base_next = top_base_reg + COL_STEP;
                    end
                    clr_col_next = '0;
                    state_next   = ST_CLEAR;
                end
            end

            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = base_reg + AW'(clr_col_reg);
                wr_data      = '0;
                clr_col_next = clr_col_reg + CW'(1);
                if (clr_col_reg == LAST_COL)
                begin
                    state_next = (cnt_reg != '0) ? ST_PUT : ST_IDLE;
                end
            end

            ST_PUT:
            begin
                if (col_reg == LAST_COL)
                begin
                    // wrap before writing
                    state_next = ST_NEWLINE;
                end
                else
                begin
                    emit_valid          = 1'b1;
                    emit_res.kind       = tcce_pkg::KIND_WRITE;
                    emit_res.row        = tcce_pkg::ROW_W'(row_reg);
                    emit_res.column     = tcce_pkg::COL_W'(col_reg);
                    emit_res.char_value = put_char_reg;
                    emit_res.last       = (cnt_reg == tcce_pkg::CNT_W'(1));
                    if (emit_ready)
                    begin
                        wr_en    = 1'b1;
                        col_next = col_reg + CW'(1);
                        cnt_next = cnt_reg - tcce_pkg::CNT_W'(1);
                        if (cnt_reg == tcce_pkg::CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_addr_reg <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            prow_reg      <= '0;
            base_reg      <= '0;
            top_reg       <= '0;
            top_base_reg  <= '0;
            cnt_reg       <= '0;
            clr_col_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_addr_reg <= init_addr_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            prow_reg      <= prow_next;
            base_reg      <= base_next;
            top_reg       <= top_next;
            top_base_reg  <= top_base_next;
            cnt_reg       <= cnt_next;
            clr_col_reg   <= clr_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        put_char_reg    <= put_char_next;
        rd_row_reg      <= rd_row_next;
        rd_col_reg      <= rd_col_next;
        rd_prow_reg     <= rd_prow_next;
        rd_in_range_reg <= rd_in_range_next;
    end

endmodule

// File: hdl/text_console_cursor_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Text console engine: cursor, scrolling character grid and cell read-back.
// ----------------------------------------------------------------------------
//  Channel  Dir  tuser        tlast  tdata (low bit up)
//  s_axis   in   command      -      char_code, read_row, read_column
//  m_axis   out  kind         last   row, column, char_value
//
//  One item at a time. A scroll also clears the new bottom row, and a read
//  goes through the grid memory read port.
//  After reset the grid is cleared, and s_axis_tready stays low until the
//  pass ends.
//  A stalled m_axis holds the sequencer at its next result beat.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_code[7:0], read_row[12:8], read_column[19:13]
    input  logic [0:0]  s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // row[4:0], column[11:5], char_value[19:12]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam int AW = $clog2(ROWS * COLUMNS);

    tcce_pkg::item_t   in_item;
    tcce_pkg::result_t emit_res;
    tcce_pkg::result_t out_res_reg;
    logic              out_valid_reg;
    logic              emit_valid;
    logic              emit_ready;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [tcce_pkg::CHAR_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [tcce_pkg::CHAR_W-1:0] rd_data;

    assign in_item.command     = s_axis_tuser[0];
    assign in_item.char_code   = s_axis_tdata[7:0];
    assign in_item.read_row    = s_axis_tdata[12:8];
    assign in_item.read_column = s_axis_tdata[19:13];

    assign emit_ready = !out_valid_reg || m_axis_tready;

    tcce_seq #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .RW      (RW),
        .CW      (CW),
        .AW      (AW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit_res   (emit_res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    tcce_grid_ram #(
        .DEPTH (ROWS * COLUMNS),
        .AW    (AW)
    ) u_grid (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register: load a beat when the slot is free or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_ready)
        begin
            out_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ready && emit_valid)
        begin
            out_res_reg <= emit_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_res_reg.char_value, out_res_reg.column, out_res_reg.row};
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.last;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text console cursor engine. A shadow console
// (grid, cursor, scroll) predicts every result beat of each accepted byte or
// read. A checker compares each m_axis beat, field by field, against the
// oldest prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int ROWS         = 25;
    localparam int COLUMNS      = 80;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_TAIL  = 200;
    localparam int MAX_GAP      = 13;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // char_code[7:0], read_row[12:8], read_column[19:13]
    logic [0:0]  s_axis_tuser = '0;     // command[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // row[4:0], column[11:5], char_value[19:12]
    logic [1:0]  m_axis_tuser;          // kind[1:0]
    logic        m_axis_tlast;

    // shadow console
    logic [tcce_pkg::CHAR_W-1:0] shadow_grid [ROWS][COLUMNS];
    logic [tcce_pkg::ROW_W-1:0]  cur_row;
    logic [tcce_pkg::COL_W-1:0]  cur_col;
    tcce_pkg::result_t           screen_events [$];
    tcce_pkg::result_t           pending_event;
    bit                          pending_valid;

    int fail_count    = 0;
    bit tx_steady     = 1'b0;
    bit rx_steady     = 1'b0;
    int rx_hold_cycles = 0;

    text_console_cursor_engine_unit #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // shadow console
    // ------------------------------------------------------------------
    task automatic emit_event(input logic [tcce_pkg::KIND_W-1:0] kind,
                              input logic [tcce_pkg::ROW_W-1:0]  row,
                              input logic [tcce_pkg::COL_W-1:0]  col,
                              input logic [tcce_pkg::CHAR_W-1:0] ch);
        if (pending_valid)
        begin
            screen_events.push_back(pending_event);
        end
        pending_event.kind       = kind;
        pending_event.row        = row;
        pending_event.column     = col;
        pending_event.char_value = ch;
        pending_event.last       = 1'b0;
        pending_valid            = 1'b1;
    endtask

    task automatic line_feed();
        cur_col = '0;
        if (cur_row < ROWS - 1)
        begin
            cur_row++;
        end
        else
        begin
            for (int r = 0; r < ROWS - 1; r++)
            begin
                for (int c = 0; c < COLUMNS; c++)
                begin
                    shadow_grid[r][c] = shadow_grid[r + 1][c];
                end
            end
            for (int c = 0; c < COLUMNS; c++)
            begin
                shadow_grid[ROWS - 1][c] = '0;
            end
            emit_event(tcce_pkg::KIND_SCROLL, '0, '0, '0);
        end
    endtask

    task automatic put_char(input logic [tcce_pkg::CHAR_W-1:0] ch);
        shadow_grid[cur_row][cur_col] = ch;
        emit_event(tcce_pkg::KIND_WRITE, cur_row, cur_col, ch);
        cur_col++;
    endtask

    task automatic console_apply(input logic cmd, input logic [tcce_pkg::CHAR_W-1:0] ch,
                                 input logic [tcce_pkg::ROW_W-1:0] rr,
                                 input logic [tcce_pkg::COL_W-1:0] rc);
        logic [tcce_pkg::CHAR_W-1:0] cell_val;
        if (cmd == tcce_pkg::CMD_READ)
        begin
            cell_val = '0;
            if (rr < ROWS && rc < COLUMNS)
            begin
                cell_val = shadow_grid[rr][rc];
            end
            emit_event(tcce_pkg::KIND_READ, rr, rc, cell_val);
        end
        else if (ch == tcce_pkg::CH_NULL)
        begin
        end
        else if (ch == tcce_pkg::CH_NL)
        begin
            line_feed();
        end
        else if (ch == tcce_pkg::CH_CR)
        begin
            cur_col = '0;
        end
        else if (cur_col < COLUMNS - 1)
        begin
            if (ch == tcce_pkg::CH_TAB)
            begin
                for (int i = 0; i < tcce_pkg::TAB_SPACES; i++)
                begin
                    if (cur_col >= COLUMNS - 1)
                    begin
                        line_feed();
                    end
                    put_char(tcce_pkg::CH_SPACE);
                end
            end
            else
            begin
                put_char(ch);
            end
        end
        else
        begin
            // wrap first; a tab here lands as its raw code
            line_feed();
            put_char(ch);
        end
        if (pending_valid)
        begin
            pending_event.last = 1'b1;
            screen_events.push_back(pending_event);
            pending_valid = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------
    task automatic send_beat(input logic cmd, input logic [tcce_pkg::CHAR_W-1:0] ch,
                             input logic [tcce_pkg::ROW_W-1:0] rr,
                             input logic [tcce_pkg::COL_W-1:0] rc);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, rc, rr, ch};
        do
        begin
            @(posedge clk);
        end
        while (s_axis_tready !== 1'b1);
        console_apply(cmd, ch, rr, rc);
    endtask

    task automatic print_byte(input logic [tcce_pkg::CHAR_W-1:0] ch);
        send_beat(tcce_pkg::CMD_PRINT, ch, tcce_pkg::ROW_W'($urandom),
                  tcce_pkg::COL_W'($urandom));
    endtask

    task automatic read_cell(input logic [tcce_pkg::ROW_W-1:0] rr,
                             input logic [tcce_pkg::COL_W-1:0] rc);
        send_beat(tcce_pkg::CMD_READ, tcce_pkg::CHAR_W'($urandom), rr, rc);
    endtask

    function automatic logic [tcce_pkg::CHAR_W-1:0] pick_glyph();
        logic [tcce_pkg::CHAR_W-1:0] g;
        do
        begin
            g = tcce_pkg::CHAR_W'($urandom_range(1, 255));
        end
        while (g == tcce_pkg::CH_TAB || g == tcce_pkg::CH_NL || g == tcce_pkg::CH_CR);
        return g;
    endfunction

    // Hold off the sender until every predicted beat is out, then let the
    // block finish any silent work.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (screen_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_TAIL) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_beat();
        tcce_pkg::result_t want;
        if (screen_events.size() == 0)
        begin
            $display("%0t: unexpected beat, expected none actual kind %0d row %0d column %0d char %0d",
                     $time, m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[11:5],
                     m_axis_tdata[19:12]);
            fail_count++;
        end
        else
        begin
            want = screen_events.pop_front();
            check_field("kind", want.kind, m_axis_tuser);
            check_field("row", want.row, m_axis_tdata[4:0]);
            check_field("column", want.column, m_axis_tdata[11:5]);
            check_field("char_value", want.char_value, m_axis_tdata[19:12]);
            check_field("last", want.last, m_axis_tlast);
        end
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
            begin
                stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (m_axis_tvalid !== 1'b1);
            check_beat();
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_readback();
        read_cell(5'd0, 7'd0);
        read_cell(tcce_pkg::ROW_W'(ROWS - 1), tcce_pkg::COL_W'(COLUMNS - 1));
        read_cell(5'd31, 7'd127);
        read_cell(5'd0, 7'd127);
        read_cell(5'd31, 7'd0);
    endtask

    task automatic test_print_controls();
        print_byte(8'd72);
        print_byte(8'hFF);
        print_byte(8'h01);
        print_byte(tcce_pkg::CH_CR);
        print_byte(8'd120);
        print_byte(tcce_pkg::CH_NULL);
        print_byte(tcce_pkg::CH_TAB);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd4);
        print_byte(tcce_pkg::CH_NL);
        print_byte(8'h80);
        print_byte(8'h7F);
        read_cell(5'd1, 7'd0);
        read_cell(5'd0, 7'd2);
    endtask

    task automatic test_line_wrap();
        int guard;
        for (int round = 0; round < 2; round++)
        begin
            guard = 0;
            print_byte(tcce_pkg::CH_CR);
            // tabs only where they cannot run past the last column
            while (cur_col < COLUMNS - 1 && guard < 200)
            begin
                if (cur_col < COLUMNS - 4 && $urandom_range(0, 1) == 0)
                begin
                    print_byte(tcce_pkg::CH_TAB);
                end
                else
                begin
                    print_byte(pick_glyph());
                end
                guard++;
            end
            // at the last column now: force a wrap
            print_byte(round == 0 ? tcce_pkg::CH_TAB : pick_glyph());
            read_cell(cur_row, 7'd0);
            read_cell(cur_row - 1'b1, tcce_pkg::COL_W'(COLUMNS - 1));
        end
    endtask

    task automatic test_scroll();
        while (cur_row < ROWS - 1)
        begin
            print_byte(tcce_pkg::CH_NL);
        end
        print_byte(pick_glyph());
        print_byte(tcce_pkg::CH_NL);
        print_byte(pick_glyph());
        print_byte(tcce_pkg::CH_TAB);
        print_byte(tcce_pkg::CH_NL);
        read_cell(tcce_pkg::ROW_W'(ROWS - 2), 7'd0);
        read_cell(tcce_pkg::ROW_W'(ROWS - 1), 7'd0);
        print_byte(tcce_pkg::CH_NL);
        read_cell(tcce_pkg::ROW_W'(ROWS - 3), 7'd1);
    endtask

    task automatic test_random_mix();
        int sel;
        for (int seg = 0; seg < 7; seg++)
        begin
            tx_steady = (seg == 0) || ($urandom_range(0, 3) == 0);
            rx_steady = (seg == 0) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 10; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 35)
                begin
                    print_byte(pick_glyph());
                end
                else if (sel < 45)
                begin
                    print_byte(tcce_pkg::CH_TAB);
                end
                else if (sel < 55)
                begin
                    print_byte(tcce_pkg::CH_NL);
                end
                else if (sel < 60)
                begin
                    print_byte(tcce_pkg::CH_CR);
                end
                else if (sel < 65)
                begin
                    print_byte(tcce_pkg::CH_NULL);
                end
                else if (sel < 82)
                begin
                    read_cell(cur_row, tcce_pkg::COL_W'($urandom_range(0, COLUMNS - 1)));
                end
                else
                begin
                    read_cell(tcce_pkg::ROW_W'($urandom), tcce_pkg::COL_W'($urandom));
                end
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        rx_hold_cycles = 300;
        tx_steady = 1'b1;
        for (int i = 0; i < 15; i++)
        begin
            case (i % 3)
                0: print_byte(pick_glyph());
                1: print_byte(tcce_pkg::CH_TAB);
                default: read_cell(cur_row, tcce_pkg::COL_W'($urandom_range(0, COLUMNS - 1)));
            endcase
        end
        tx_steady = 1'b0;
    endtask

    initial
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLUMNS; c++)
            begin
                shadow_grid[r][c] = '0;
            end
        end
        cur_row       = '0;
        cur_col       = '0;
        pending_valid = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_readback();
        test_print_controls();
        settle_block();
        test_line_wrap();
        settle_block();
        test_scroll();
        settle_block();
        test_random_mix();
        settle_block();
        test_backpressure();
        settle_block();

        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
